// ===== hw/rtl/bb3_pkg.sv =====
// bb3_pkg: shared types, register indexes and the rounded-mean function
// for the 3x3 box blur
// no dependencies
package bb3_pkg;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int SUM_W        = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;

  // reciprocals for the divide by 6 and by 18
  localparam logic [16:0] RECIP_6  = 17'd87382;
  localparam logic [15:0] RECIP_18 = 16'd58255;

  typedef logic [23:0] pix_t;

  typedef enum logic [1:0] {
    CNT_4,
    CNT_6,
    CNT_9
  } cnt_code_t;

  // per-pixel job seed, captured at input acceptance
  typedef struct packed {
    logic [3:0]       mask;
    logic             r1;
    logic             c1;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } seed_t;

  // one result request from the window to the mean unit
  typedef struct packed {
    logic             rlo;
    logic             clo;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             done;
  } job_t;

  // (2*sum + n) / (2*n), rounded half up
  function automatic logic [7:0] mean8(input logic [SUM_W-1:0] s, input cnt_code_t n);
    logic [SUM_W-1:0] x6;
    logic [12:0]      x9;
    logic [SUM_W-1:0] x4;
    logic [28:0]      p6;
    logic [28:0]      p9;
    logic [7:0]       q;
    x4 = s + SUM_W'(2);
    x6 = s + SUM_W'(3);
    x9 = {s, 1'b0} + 13'd9;
    p6 = 29'(x6) * 29'(RECIP_6);
    p9 = 29'(x9) * 29'(RECIP_18);
    case (n)
      CNT_4:   q = x4[9:2];
      CNT_6:   q = p6[26:19];
      default: q = p9[27:20];
    endcase
    return q;
  endfunction

endpackage

// ===== hw/rtl/bb3_if.sv =====
// bb3_if: valid/ready channel interfaces for pixels in and results out
// no dependencies
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        last_of_run;
  logic        frame_done;
  modport source(output valid, red_out, green_out, blue_out, out_row, out_col,
                 last_of_run, frame_done, input ready);
  modport sink(input valid, red_out, green_out, blue_out, out_row, out_col,
               last_of_run, frame_done, output ready);
endinterface

// ===== hw/rtl/box_blur_3x3_edge_aware.sv =====
// box_blur_3x3_edge_aware: edge-aware 3x3 rgb box blur over a raster pixel stream
// path: input register, window registers, sum register, output register; one pixel a cycle
//   unless the output stalls, and a pixel with n results (2 at row ends and on the last row,
//   4 at the frame's last pixel) waits while the one-result-a-cycle sequencer issues them
// reset: synchronous, active low; width 640, height 480, counters and window cleared
// depends on bb3_pkg, bb3_if, bb3_line_mem, bb3_window, bb3_mean
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bb3_in_if.sink                         in_px,
  bb3_out_if.source                      out_px,
  input  logic                           cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bb3_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [31:0]             w_eff;
  logic [31:0]             h_eff;

  // position of the next input pixel
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // pixel waiting for its line store read
  logic          s1_v_r;
  pix_t          s1_px_r;
  logic [CW-1:0] s1_col_r;
  seed_t         s1_seed_r;
  seed_t         seed_nxt;

  logic          in_acc;
  logic          ld;
  logic          win_free;
  logic [47:0]   rd_data;
  logic          last_col, last_row;

  pix_t          win [9];
  logic          job_valid;
  logic          job_ready;
  job_t          job;

  // frame size clamped to the supported range
  always_comb begin
    w_eff = 32'(width_r);
    if (w_eff < 32'd2) begin
      w_eff = 32'd2;
    end else if (w_eff > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end
    h_eff = 32'(height_r);
    if (h_eff < 32'd2) begin
      h_eff = 32'd2;
    end else if (h_eff > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end
  end

  assign last_col = (32'(col_r) + 32'd1) == w_eff;
  assign last_row = (32'(row_r) + 32'd1) == h_eff;

  assign in_px.ready = !s1_v_r || ld;
  assign in_acc      = in_px.valid && in_px.ready;
  assign ld          = s1_v_r && win_free;

  // raster counters, wrap at row and frame ends
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // which results this pixel causes: bit 0 the row above, bit 1 its last column,
  // bit 2 the last row, bit 3 the frame's last pixel
  always_comb begin
    seed_nxt.mask[0] = (row_r != '0) && (col_r != '0);
    seed_nxt.mask[1] = (row_r != '0) && last_col;
    seed_nxt.mask[2] = last_row && (col_r != '0);
    seed_nxt.mask[3] = last_row && last_col;
    seed_nxt.r1      = (32'(row_r) == 32'd1);
    seed_nxt.c1      = (32'(col_r) == 32'd1);
    seed_nxt.row     = ROW_W'(row_r);
    seed_nxt.col     = COL_W'(col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      // a width or height write restarts the frame
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH: begin
            width_r <= cfg_data[WIDTH_REG_W-1:0];
            col_r   <= '0;
            row_r   <= '0;
          end
          CFG_HEIGHT: begin
            height_r <= cfg_data;
            col_r    <= '0;
            row_r    <= '0;
          end
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (ld) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= {in_px.red_in, in_px.green_in, in_px.blue_in};
      s1_col_r  <= col_r;
      s1_seed_r <= seed_nxt;
    end
  end

  // entry holds {two rows up, one row up}; the write shifts the column down
  bb3_line_mem #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (in_acc),
    .rd_addr(col_r),
    .rd_data(rd_data),
    .wr_en  (ld),
    .wr_addr(s1_col_r),
    .wr_data({rd_data[23:0], s1_px_r})
  );

  bb3_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .above2   (rd_data[47:24]),
    .above1   (rd_data[23:0]),
    .px       (s1_px_r),
    .seed     (s1_seed_r),
    .free     (win_free),
    .win      (win),
    .job_valid(job_valid),
    .job      (job),
    .job_ready(job_ready)
  );

  bb3_mean u_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .win      (win),
    .job_valid(job_valid),
    .job      (job),
    .job_ready(job_ready),
    .out_px   (out_px)
  );
endmodule

// ===== hw/rtl/bb3_line_mem.sv =====
// bb3_line_mem: line store, one entry per column holding the two rows above
// no dependencies
module bb3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [47:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [47:0]   wr_data
);
  logic [47:0] mem [DEPTH];
  logic [47:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== hw/rtl/bb3_window.sv =====
// bb3_window: 3x3 window registers and the result sequencer
// depends on bb3_pkg
module bb3_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld,
  input  bb3_pkg::pix_t       above2,
  input  bb3_pkg::pix_t       above1,
  input  bb3_pkg::pix_t       px,
  input  bb3_pkg::seed_t      seed,
  output logic                free,
  output bb3_pkg::pix_t       win [9],
  output logic                job_valid,
  output bb3_pkg::job_t       job,
  input  logic                job_ready
);
  import bb3_pkg::*;

  pix_t       win_r [9];
  seed_t      seed_r;
  logic [3:0] mask_clr;
  logic [3:0] pick;
  logic       issue;

  function automatic logic [3:0] mask_r_low(input logic [3:0] m);
    return m & (~m + 4'd1);
  endfunction

  always_comb begin
    pick = mask_r_low(seed_r.mask);
    mask_clr = seed_r.mask & ~pick;
  end

  assign job_valid = |seed_r.mask;
  assign issue     = job_valid && job_ready;
  assign free      = !job_valid || (issue && (mask_clr == 4'd0));

  always_comb begin
    job.last = (mask_clr == 4'd0);
    job.done = 1'b0;
    job.rlo  = 1'b1;
    job.clo  = 1'b1;
    job.row  = seed_r.row;
    job.col  = seed_r.col;
    case (pick)
      4'b0001: begin
        job.rlo = seed_r.r1;
        job.clo = seed_r.c1;
        job.row = seed_r.row - ROW_W'(1);
        job.col = seed_r.col - COL_W'(1);
      end
      4'b0010: begin
        job.rlo = seed_r.r1;
        job.row = seed_r.row - ROW_W'(1);
      end
      4'b0100: begin
        job.clo = seed_r.c1;
        job.col = seed_r.col - COL_W'(1);
      end
      default: begin
        job.done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r.mask <= 4'd0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (ld) begin
      seed_r <= seed;
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= above2;
      win_r[5] <= above1;
      win_r[8] <= px;
    end else if (issue) begin
      seed_r.mask <= mask_clr;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win[i] = win_r[i];
    end
  end
endmodule

// ===== hw/rtl/bb3_mean.sv =====
// bb3_mean: masked window sums, then rounded means into the output register
// depends on bb3_pkg and bb3_if
module bb3_mean (
  input  logic            clk,
  input  logic            rst_n,
  input  bb3_pkg::pix_t   win [9],
  input  logic            job_valid,
  input  bb3_pkg::job_t   job,
  output logic            job_ready,
  bb3_out_if.source       out_px
);
  import bb3_pkg::*;

  logic             a_v_r;
  logic [SUM_W-1:0] a_sum_r [3];
  cnt_code_t        a_cnt_r;
  job_t             a_job_r;
  logic [SUM_W-1:0] sum_nxt [3];
  cnt_code_t        cnt_nxt;
  logic             b_load;
  logic             a_load;
  logic             out_v_r;

  assign b_load    = a_v_r && (!out_v_r || out_px.ready);
  assign job_ready = !a_v_r || b_load;
  assign a_load    = job_valid && job_ready;

  // sum over rows rlo..2 and columns clo..2
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i >= 32'(job.rlo)) && (j >= 32'(job.clo))) begin
            sum_nxt[ch] = sum_nxt[ch] + SUM_W'(win[i*3+j][ch*8 +: 8]);
          end
        end
      end
    end
    if (job.rlo && job.clo) begin
      cnt_nxt = CNT_4;
    end else if (job.rlo || job.clo) begin
      cnt_nxt = CNT_6;
    end else begin
      cnt_nxt = CNT_9;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_v_r <= 1'b1;
      end else if (b_load) begin
        a_v_r <= 1'b0;
      end
      if (b_load) begin
        out_v_r <= 1'b1;
      end else if (out_px.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_sum_r <= sum_nxt;
      a_cnt_r <= cnt_nxt;
      a_job_r <= job;
    end
    if (b_load) begin
      out_px.red_out     <= mean8(a_sum_r[2], a_cnt_r);
      out_px.green_out   <= mean8(a_sum_r[1], a_cnt_r);
      out_px.blue_out    <= mean8(a_sum_r[0], a_cnt_r);
      out_px.out_row     <= a_job_r.row;
      out_px.out_col     <= a_job_r.col;
      out_px.last_of_run <= a_job_r.last;
      out_px.frame_done  <= a_job_r.done;
    end
  end

  assign out_px.valid = out_v_r;
endmodule

// ===== hw/rtl/bb3_checker.sv =====
// bb3_checker: port-level assertions for the box blur, bound to the top level
// depends on box_blur_3x3_edge_aware
module bb3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  red_out,
  input logic [11:0] out_row,
  input logic [9:0]  out_col,
  input logic        last_of_run,
  input logic        frame_done
);
  // the frame's last result always closes its transaction's run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  // a stalled result stays valid and holds its red value, row, column and last flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(out_row)
      && $stable(out_col) && $stable(last_of_run))
    else $error("stalled result changed");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind box_blur_3x3_edge_aware bb3_checker u_bb3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_px.valid),
  .out_ready  (out_px.ready),
  .red_out    (out_px.red_out),
  .out_row    (out_px.out_row),
  .out_col    (out_px.out_col),
  .last_of_run(out_px.last_of_run),
  .frame_done (out_px.frame_done)
);

// ===== tb/bb3_blur_checker.sv =====
// bb3_blur_checker: watches the pixel and result channels, predicts blurred pixels
// depends on bb3_pkg and bb3_if
`timescale 1ns / 100ps
module bb3_blur_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bb3_in_if                              in_px,
  bb3_out_if                             out_px,
  input  logic                           cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             results_seen
);
  import bb3_pkg::*;

  typedef struct {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             done;
  } blur_px_t;

  blur_px_t blurred_q[$];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  pix_t row_above1[MAX_WIDTH];
  pix_t row_above2[MAX_WIDTH];
  pix_t win[3][3];
  int   next_row, next_col;

  assign pending = blurred_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (row %0d col %0d)", what, got, want,
             out_px.out_row, out_px.out_col);
    fail_count++;
  endtask

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic blur_px_t average(input int rlo, input int clo, input int row,
                                       input int col, input bit done);
    blur_px_t p;
    int sr, sg, sb, cnt;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int i = rlo; i < 3; i++)
      for (int j = clo; j < 3; j++) begin
        sr += win[i][j][23:16];
        sg += win[i][j][15:8];
        sb += win[i][j][7:0];
        cnt++;
      end
    p.red   = 8'((2 * sr + cnt) / (2 * cnt));
    p.green = 8'((2 * sg + cnt) / (2 * cnt));
    p.blue  = 8'((2 * sb + cnt) / (2 * cnt));
    p.row   = ROW_W'(row);
    p.col   = COL_W'(col);
    p.last  = 1'b0;
    p.done  = done;
    return p;
  endfunction

  task automatic predict_pixel(input pix_t px);
    blur_px_t res[$];
    int w, h, r, c, clo, rlo;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = next_row;
    c = next_col;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = row_above2[c];
    win[1][2] = row_above1[c];
    win[2][2] = px;
    row_above2[c] = row_above1[c];
    row_above1[c] = px;
    clo = (c == 1) ? 1 : 0;
    rlo = (r == 1) ? 1 : 0;
    if (r >= 1) begin
      if (c >= 1) res.push_back(average(rlo, clo, r - 1, c - 1, 0));
      if (c == w - 1) res.push_back(average(rlo, 1, r - 1, w - 1, 0));
    end
    if (r == h - 1) begin
      if (c >= 1) res.push_back(average(1, clo, r, c - 1, 0));
      if (c == w - 1) res.push_back(average(1, 1, r, w - 1, 1));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) blurred_q.push_back(res[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  always @(posedge clk) begin
    blur_px_t e;
    if (!rst_n) begin
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
      next_row   = 0;
      next_col   = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) begin
          width_reg <= cfg_data[WIDTH_REG_W-1:0];
          next_row = 0; next_col = 0;
        end else if (cfg_index == CFG_HEIGHT) begin
          height_reg <= cfg_data;
          next_row = 0; next_col = 0;
        end
      end
      if (in_px.valid && in_px.ready)
        predict_pixel({in_px.red_in, in_px.green_in, in_px.blue_in});
      if (out_px.valid && out_px.ready) begin
        results_seen++;
        if (blurred_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = blurred_q.pop_front();
          if (out_px.red_out !== e.red) report("red", out_px.red_out, e.red);
          if (out_px.green_out !== e.green) report("green", out_px.green_out, e.green);
          if (out_px.blue_out !== e.blue) report("blue", out_px.blue_out, e.blue);
          if (out_px.out_row !== e.row) report("row", out_px.out_row, e.row);
          if (out_px.out_col !== e.col) report("col", out_px.out_col, e.col);
          if (out_px.last_of_run !== e.last) report("last", out_px.last_of_run, e.last);
          if (out_px.frame_done !== e.done) report("done", out_px.frame_done, e.done);
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    results_seen = 0;
  end
endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for the 3x3 edge-aware box blur
// depends on bb3_pkg, bb3_if, bb3_blur_checker and the block itself
`timescale 1ns / 100ps
module tb;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int   fail_count, pending, results_seen;
  int   cycles;
  int   frames_run;
  int   pixels_sent;

  bb3_in_if  in_px();
  bb3_out_if out_px();

  box_blur_3x3_edge_aware u_top (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .out_px(out_px),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bb3_blur_checker u_check (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .out_px(out_px),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: a random stall before each transaction
  initial begin
    int stall;
    out_px.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        out_px.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_px.ready <= 1'b1;
      @(posedge clk iff out_px.valid);
    end
  end

  // one pixel transaction, with a random gap before it
  // when keep_up is set the gap is skipped so valid stays high back to back
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input bit keep_up);
    int gap;
    gap = keep_up ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid    <= 1'b1;
    in_px.red_in   <= r;
    in_px.green_in <= g;
    in_px.blue_in  <= b;
    @(posedge clk iff in_px.ready);
    pixels_sent++;
  endtask

  // drop valid and wait for every expected result plus the block's latency
  task automatic drain;
    in_px.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // a full frame; mode 0 random, 1 all extremes alternating, 2 bit walk
  task automatic run_frame(input int w, input int h, input int mode);
    logic [7:0] v;
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    for (int i = 0; i < w * h; i++) begin
      case (mode)
        1: begin
          v = (i % 2) ? 8'hFF : 8'h00;
          send_pixel(v, ~v, v, ($urandom_range(0, 3) == 0));
        end
        2: begin
          v = 8'(1 << (i % 8));
          send_pixel(v, ~v, 8'(i * 37), 1'b0);
        end
        default: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), ($urandom_range(0, 2) == 0));
      endcase
    end
    // sender holds off until every result of the frame is back
    drain();
    frames_run++;
  endtask

  initial begin
    int w, h;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_WIDTH;
    cfg_data       = '0;
    in_px.valid    = 1'b0;
    in_px.red_in   = '0;
    in_px.green_in = '0;
    in_px.blue_in  = '0;
    frames_run     = 0;
    pixels_sent    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frame, height-2 special case, extremes, clamped sizes
    run_frame(2, 2, 1);
    run_frame(3, 2, 2);
    run_frame(2, 3, 1);
    run_frame(0, 1, 0);              // both clamp up to 2x2
    // width above the limit clamps to MAX_WIDTH; keep it sane
    run_frame(4, 3, 2);

    // unknown register index does nothing
    write_reg(2'd3, 13'h1FFF);

    // random frames, mostly small
    while (pixels_sent < 105) begin
      w = $urandom_range(2, 6);
      h = $urandom_range(2, 5);
      run_frame(w, h, 0);
    end
    // height register with its top bit set clamps to MAX_HEIGHT; only part of the frame sent
    write_reg(CFG_HEIGHT, 13'h1FFF);
    write_reg(CFG_WIDTH, 11'h7FF);
    write_reg(CFG_WIDTH, 3);
    for (int i = 0; i < 9; i++)
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 0);
    drain();

    $display("covered %0d frames, %0d pixels in, %0d blurred pixels out",
             frames_run, pixels_sent, results_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
